// ----- design/conv3_pkg.sv -----
// Package for the 3x3 clamped convolution core.
// Holds field widths, register map codes, reset values and shared types.
// No dependencies.
package conv3_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int FW_BITS        = 11;
   localparam int FH_BITS        = 12;
   localparam int KERNEL_BITS    = 48;
   localparam int SLOT_BITS      = 16;
   localparam int ROWS           = 3;
   localparam int TAPS           = 9;
   localparam int MIN_DIM        = 3;
   localparam int WINDOW_EDGE    = 2;

   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_DATA_BITS  = 64;
   localparam int REG_INDEX_BITS = 3;

   localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_KERNEL_MID    = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

   localparam logic [FW_BITS-1:0]     FRAME_WIDTH_RESET   = 11'd640;
   localparam logic [FH_BITS-1:0]     FRAME_HEIGHT_RESET  = 12'd480;
   localparam logic [KERNEL_BITS-1:0] KERNEL_TOP_RESET    = 48'd0;
   localparam logic [KERNEL_BITS-1:0] KERNEL_MID_RESET    = 48'd65536;
   localparam logic [KERNEL_BITS-1:0] KERNEL_BOTTOM_RESET = 48'd0;

   localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = 8'd255;

   typedef logic [PIXEL_BITS-1:0]  pixel_type;
   typedef logic [KERNEL_BITS-1:0] kernel_type;

   typedef struct packed {
      logic bank;
      logic emit;
      logic last;
   } scan_flags_type;

endpackage

// ----- design/conv3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module conv3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/conv3_scan.sv -----
// Raster position tracker: column and row counters, wrap on frame size.
// Depends on conv3_pkg.
module conv3_scan import conv3_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [FW_BITS-1:0]  frame_width,
   input  logic [FH_BITS-1:0]  frame_height,
   output logic [COL_BITS-1:0] col,
   output scan_flags_type      flags
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int LW = ((WW > FW_BITS) ? WW : FW_BITS) + 1;
   localparam int RW = FH_BITS + 1;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [FH_BITS-1:0]  row_ff, row_in;
   logic [LW-1:0]       width_eff, col_e, col_n;
   logic [RW-1:0]       height_eff, row_t, row_e, row_n;

   always_comb begin
      width_eff = LW'(frame_width);
      if (width_eff > LW'(MAX_WIDTH)) width_eff = LW'(MAX_WIDTH);
      if (width_eff < LW'(MIN_DIM)) width_eff = LW'(MIN_DIM);
      height_eff = RW'(frame_height);
      if (height_eff < RW'(MIN_DIM)) height_eff = RW'(MIN_DIM);

      // wrap on entry when the frame size shrank
      row_t = RW'(row_ff);
      if (LW'(col_ff) >= width_eff) begin
         col_e = '0;
         row_t = row_t + RW'(1);
      end else begin
         col_e = LW'(col_ff);
      end
      if (row_t >= height_eff) row_e = '0;
      else row_e = row_t;

      flags.bank = row_e[0];
      flags.emit = (row_e >= RW'(WINDOW_EDGE)) && (col_e >= LW'(WINDOW_EDGE));
      flags.last = (row_e == height_eff - RW'(1)) && (col_e == width_eff - LW'(1));

      col_n = col_e + LW'(1);
      row_n = row_e;
      if (col_n >= width_eff) begin
         col_n = '0;
         row_n = row_e + RW'(1);
         if (row_n >= height_eff) row_n = '0;
      end

      col_in = advance ? COL_BITS'(col_n) : col_ff;
      row_in = advance ? FH_BITS'(row_n) : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = COL_BITS'(col_e);

endmodule

// ----- design/conv3_mac.sv -----
// Multiply-accumulate pipeline: nine products, three row sums, sum and clamp.
// Depends on conv3_pkg; drives the result channel.
module conv3_mac import conv3_pkg::*; #(
   parameter int COEF_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_last,
   input  pixel_type [TAPS-1:0]  pix,
   input  kernel_type [ROWS-1:0] kern,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_BITS-1:0] rsp_pixel_out,
   output logic                  rsp_frame_end
);

   localparam int PROD_BITS = COEF_BITS + PIXEL_BITS + 1;
   localparam int ROW_BITS  = PROD_BITS + 2;
   localparam int SUM_BITS  = PROD_BITS + 4;

   logic signed [PROD_BITS-1:0] coef_x [TAPS];
   logic signed [PROD_BITS-1:0] pix_x  [TAPS];
   logic signed [PROD_BITS-1:0] prod_in [TAPS];
   logic signed [PROD_BITS-1:0] prod_ff [TAPS];
   logic signed [ROW_BITS-1:0]  row_in  [ROWS];
   logic signed [ROW_BITS-1:0]  row_ff  [ROWS];
   logic signed [SUM_BITS-1:0]  sum;

   logic prod_valid_ff, prod_valid_in, prod_last_ff, prod_ready;
   logic row_valid_ff, row_valid_in, row_last_ff, row_ready;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, out_ready;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff, rsp_pixel_in;

   assign out_ready  = !rsp_valid_ff || rsp_ready;
   assign row_ready  = !row_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || row_ready;
   assign in_ready   = prod_ready;

   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      assign coef_x[t]  = PROD_BITS'($signed(kern[t / ROWS][SLOT_BITS * (t % ROWS) +: COEF_BITS]));
      assign pix_x[t]   = PROD_BITS'({1'b0, pix[t]});
      assign prod_in[t] = PROD_BITS'(coef_x[t] * pix_x[t]);
   end

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      assign row_in[r] = ROW_BITS'(prod_ff[ROWS * r]) + ROW_BITS'(prod_ff[ROWS * r + 1])
                       + ROW_BITS'(prod_ff[ROWS * r + 2]);
   end

   always_comb begin
      sum = SUM_BITS'(row_ff[0]) + SUM_BITS'(row_ff[1]) + SUM_BITS'(row_ff[2]);
      if (sum[SUM_BITS-1]) rsp_pixel_in = '0;
      else if (|sum[SUM_BITS-2:PIXEL_BITS]) rsp_pixel_in = PIXEL_MAX;
      else rsp_pixel_in = sum[PIXEL_BITS-1:0];

      prod_valid_in = prod_ready ? in_valid : prod_valid_ff;
      row_valid_in  = row_ready ? prod_valid_ff : row_valid_ff;
      rsp_valid_in  = out_ready ? row_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         row_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         row_valid_ff  <= row_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         prod_ff      <= prod_in;
         prod_last_ff <= in_last;
      end
      if (row_ready && prod_valid_ff) begin
         row_ff      <= row_in;
         row_last_ff <= prod_last_ff;
      end
      if (out_ready && row_valid_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_last_ff  <= row_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_last_ff;

endmodule

// ----- design/conv3x3_clamped_core.sv -----
// 3x3 convolution core for 8-bit grayscale pixels, clamped to 0..255.
// Depends on conv3_pkg, conv3_ram, conv3_scan and conv3_mac.
//
// Usage: pixels enter in raster order on the req_ channel, one word per
// valid/ready handshake. Each pixel at row >= 2 and column >= 2 completes
// a 3x3 window and yields one word on the rsp_ channel: the filtered pixel
// at (row-1, col-1) and rsp_frame_end, set on the last result of a frame.
// Border pixels yield no word. Frame size and the three kernel rows are set
// through the APB port (64-bit data, register i at byte address 8*i) while
// the core is idle.
// Throughput: one pixel per cycle while the receiver keeps up. A result passes
// the input stage with line buffer read, the product stage, the row sum
// stage, and the sum and clamp output register before it shows on rsp_valid.
// The line buffer is one RAM of MAX_WIDTH words, each holding both stored
// rows at a column, read and written once per pixel.
// When the receiver stalls, the pipeline stages fill and req_ready drops
// only once every stage holds a word.
// Reset: counters return to the frame origin, the window clears and the
// registers take their defaults (640x480, identity kernel).
module conv3x3_clamped_core import conv3_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int COEF_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIXEL_BITS-1:0]    req_pixel_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PIXEL_BITS-1:0]    rsp_pixel_out,
   output logic                     rsp_frame_end,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LINE_BITS = 2 * PIXEL_BITS;

   logic [FW_BITS-1:0] frame_width_ff;
   logic [FH_BITS-1:0] frame_height_ff;
   kernel_type         kernel_top_ff, kernel_mid_ff, kernel_bottom_ff;
   logic               csr_write;
   logic [REG_INDEX_BITS-1:0] csr_index;

   logic                  req_accept;
   logic [COL_BITS-1:0]   scan_col;
   scan_flags_type        scan_flags;

   logic                  s1_valid_ff, s1_valid_in, s1_adv;
   pixel_type             s1_pixel_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   scan_flags_type        s1_flags_ff;

   pixel_type             win_ff [6];
   pixel_type             win_in [6];
   logic [LINE_BITS-1:0]  ram_rdata, ram_wdata;
   logic                  ram_we, ram_re;
   logic [COL_BITS-1:0]   ram_waddr, ram_raddr;
   pixel_type             top_pix, mid_pix;

   logic                  mac_in_valid, mac_in_ready;
   pixel_type [TAPS-1:0]  mac_pix;
   kernel_type [ROWS-1:0] mac_kern;

   // configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_BITS-1:CSR_ADDR_BITS-REG_INDEX_BITS];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RESET;
         frame_height_ff  <= FRAME_HEIGHT_RESET;
         kernel_top_ff    <= KERNEL_TOP_RESET;
         kernel_mid_ff    <= KERNEL_MID_RESET;
         kernel_bottom_ff <= KERNEL_BOTTOM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:   frame_width_ff   <= pwdata[FW_BITS-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff  <= pwdata[FH_BITS-1:0];
            REG_KERNEL_TOP:    kernel_top_ff    <= pwdata[KERNEL_BITS-1:0];
            REG_KERNEL_MID:    kernel_mid_ff    <= pwdata[KERNEL_BITS-1:0];
            REG_KERNEL_BOTTOM: kernel_bottom_ff <= pwdata[KERNEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:   prdata = CSR_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT:  prdata = CSR_DATA_BITS'(frame_height_ff);
         REG_KERNEL_TOP:    prdata = CSR_DATA_BITS'(kernel_top_ff);
         REG_KERNEL_MID:    prdata = CSR_DATA_BITS'(kernel_mid_ff);
         REG_KERNEL_BOTTOM: prdata = CSR_DATA_BITS'(kernel_bottom_ff);
         default:           prdata = '0;
      endcase
   end

   // input stage
   assign req_accept = req_valid && req_ready;
   assign s1_adv     = s1_valid_ff && (!s1_flags_ff.emit || mac_in_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;

   conv3_scan #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_accept),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .col          (scan_col),
      .flags        (scan_flags)
   );

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel_in;
         s1_col_ff   <= scan_col;
         s1_flags_ff <= scan_flags;
      end
   end

   // line buffer: low half holds even rows, high half odd rows
   assign ram_re    = req_accept;
   assign ram_raddr = scan_col;
   assign ram_we    = s1_adv;
   assign ram_waddr = s1_col_ff;
   assign top_pix   = s1_flags_ff.bank ? ram_rdata[LINE_BITS-1:PIXEL_BITS]
                                       : ram_rdata[PIXEL_BITS-1:0];
   assign mid_pix   = s1_flags_ff.bank ? ram_rdata[PIXEL_BITS-1:0]
                                       : ram_rdata[LINE_BITS-1:PIXEL_BITS];
   assign ram_wdata = s1_flags_ff.bank ? {s1_pixel_ff, ram_rdata[PIXEL_BITS-1:0]}
                                       : {ram_rdata[LINE_BITS-1:PIXEL_BITS], s1_pixel_ff};

   conv3_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // window: entries 0..2 column c-2, 3..5 column c-1, top to bottom
   always_comb begin
      win_in[0] = win_ff[3];
      win_in[1] = win_ff[4];
      win_in[2] = win_ff[5];
      win_in[3] = top_pix;
      win_in[4] = mid_pix;
      win_in[5] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   assign mac_in_valid = s1_valid_ff && s1_flags_ff.emit;
   assign mac_pix  = {s1_pixel_ff, win_ff[5], win_ff[2],
                      mid_pix, win_ff[4], win_ff[1],
                      top_pix, win_ff[3], win_ff[0]};
   assign mac_kern = {kernel_bottom_ff, kernel_mid_ff, kernel_top_ff};

   conv3_mac #(
      .COEF_BITS(COEF_BITS)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mac_in_valid),
      .in_ready      (mac_in_ready),
      .in_last       (s1_flags_ff.last),
      .pix           (mac_pix),
      .kern          (mac_kern),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end)
   );

`ifndef ASSERT_OFF
   a_line_no_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("line buffer read and write hit the same column");

   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted pixel missing from input stage");

   a_emit_inside_frame: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_flags_ff.emit) |-> (s1_col_ff >= COL_BITS'(WINDOW_EDGE)))
      else $error("result flagged for a border column");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for conv3x3_clamped_core: 3x3 clamped convolution over a pixel stream.
// Predicts each filtered word from the pixel stream and the register settings.
// Depends on conv3_pkg and the core RTL only.
module tb;
   import conv3_pkg::*;

   localparam int MAX_W = 1024;
   localparam int IDLE_PCT = 24;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      pixel_type pixel;
      logic      frame_end;
   } filtered_word_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [PIXEL_BITS-1:0]    req_pixel_in;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [PIXEL_BITS-1:0]    rsp_pixel_out;
   logic                     rsp_frame_end;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   filtered_word_type expected_words[$];

   pixel_type          line_mem [2*MAX_W];
   pixel_type          window_q [6];
   int                 col_pos;
   int                 row_pos;
   logic [FW_BITS-1:0] width_reg;
   logic [FH_BITS-1:0] height_reg;
   kernel_type         kernel_top_reg;
   kernel_type         kernel_mid_reg;
   kernel_type         kernel_bottom_reg;

   bit calm;
   bit hold_off;
   int error_count;
   int pixels_sent;
   int words_checked;
   int frame_ends;
   int csr_writes;

   conv3x3_clamped_core #(
      .MAX_WIDTH(MAX_W),
      .COEF_BITS(16)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel_in (req_pixel_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_frame_end(rsp_frame_end),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int frame_cols();
      int w;
      w = width_reg;
      if (w > MAX_W) w = MAX_W;
      if (w < MIN_DIM) w = MIN_DIM;
      return w;
   endfunction

   function automatic int frame_rows();
      int h;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   function automatic int tap_weight(kernel_type k, int slot);
      logic signed [SLOT_BITS-1:0] c;
      c = k[slot*SLOT_BITS +: SLOT_BITS];
      return int'(c);
   endfunction

   function automatic int row_product(kernel_type k, pixel_type a, pixel_type b, pixel_type c);
      return tap_weight(k, 0) * int'(a) + tap_weight(k, 1) * int'(b) + tap_weight(k, 2) * int'(c);
   endfunction

   function automatic void predict_pixel(pixel_type value);
      int w;
      int h;
      int col;
      int bank;
      int sum;
      pixel_type top;
      pixel_type mid;
      filtered_word_type word;
      w = frame_cols();
      h = frame_rows();
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      col = col_pos % MAX_W;
      bank = row_pos & 1;
      top = line_mem[bank*MAX_W + col];
      mid = line_mem[(1-bank)*MAX_W + col];
      line_mem[bank*MAX_W + col] = value;
      if (row_pos >= 2 && col_pos >= 2) begin
         sum = row_product(kernel_top_reg, window_q[0], window_q[3], top)
             + row_product(kernel_mid_reg, window_q[1], window_q[4], mid)
             + row_product(kernel_bottom_reg, window_q[2], window_q[5], value);
         if (sum < 0) sum = 0;
         if (sum > int'(PIXEL_MAX)) sum = int'(PIXEL_MAX);
         word.pixel = pixel_type'(sum);
         word.frame_end = (row_pos == h - 1 && col_pos == w - 1);
         expected_words.push_back(word);
      end
      window_q[0] = window_q[3];
      window_q[1] = window_q[4];
      window_q[2] = window_q[5];
      window_q[3] = top;
      window_q[4] = mid;
      window_q[5] = value;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic pixel_type random_pixel();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return PIXEL_MAX;
      return pixel_type'($urandom);
   endfunction

   function automatic kernel_type random_kernel();
      kernel_type k;
      logic [SLOT_BITS-1:0] extremes [4];
      extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
      for (int s = 0; s < ROWS; s++) begin
         case ($urandom_range(3))
            0, 1: k[s*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom_range(16) - 8);
            2: k[s*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom);
            default: k[s*SLOT_BITS +: SLOT_BITS] = extremes[$urandom_range(3)];
         endcase
      end
      return k;
   endfunction

   task automatic send_pixel(input pixel_type value);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= value;
      do @(posedge clock); while (!req_ready);
      predict_pixel(value);
      pixels_sent++;
   endtask

   task automatic send_frame();
      repeat (frame_cols() * frame_rows()) send_pixel(random_pixel());
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] stored;
      stored = '0;
      case (index)
         REG_FRAME_WIDTH: begin
            width_reg = value[FW_BITS-1:0];
            stored = CSR_DATA_BITS'(width_reg);
         end
         REG_FRAME_HEIGHT: begin
            height_reg = value[FH_BITS-1:0];
            stored = CSR_DATA_BITS'(height_reg);
         end
         REG_KERNEL_TOP: begin
            kernel_top_reg = value[KERNEL_BITS-1:0];
            stored = CSR_DATA_BITS'(kernel_top_reg);
         end
         REG_KERNEL_MID: begin
            kernel_mid_reg = value[KERNEL_BITS-1:0];
            stored = CSR_DATA_BITS'(kernel_mid_reg);
         end
         REG_KERNEL_BOTTOM: begin
            kernel_bottom_reg = value[KERNEL_BITS-1:0];
            stored = CSR_DATA_BITS'(kernel_bottom_reg);
         end
         default: stored = '0;
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'({index, 3'b000});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== stored) begin
         error_count++;
         $error("prdata at register %0d: expected %0h, got %0h", index, stored, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   task automatic set_frame(input int w, input int h);
      csr_write(REG_FRAME_WIDTH, CSR_DATA_BITS'(w));
      csr_write(REG_FRAME_HEIGHT, CSR_DATA_BITS'(h));
   endtask

   task automatic load_kernel(input kernel_type t, input kernel_type m, input kernel_type b);
      csr_write(REG_KERNEL_TOP, {SLOT_BITS'($urandom), t});
      csr_write(REG_KERNEL_MID, {SLOT_BITS'($urandom), m});
      csr_write(REG_KERNEL_BOTTOM, {SLOT_BITS'($urandom), b});
   endtask

   // reset values: 640 wide, identity kernel; then shrink the frame mid-row
   task automatic test_reset_defaults();
      repeat (2 * int'(FRAME_WIDTH_RESET) + 16) send_pixel(random_pixel());
      wait_idle();
      set_frame(16, 3);
      send_frame();
   endtask

   task automatic test_corner_cases();
      wait_idle();
      set_frame(0, 0);
      load_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
      repeat (9) send_pixel(PIXEL_MAX);
      wait_idle();
      load_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
      repeat (9) send_pixel(PIXEL_MAX);
      wait_idle();
      load_kernel(KERNEL_TOP_RESET, KERNEL_MID_RESET, KERNEL_BOTTOM_RESET);
      for (int i = 0; i < 9; i++) send_pixel(i[0] ? PIXEL_MAX : pixel_type'(0));
   endtask

   task automatic test_random_frames();
      int start;
      int w;
      int h;
      start = pixels_sent;
      calm = 1'b1;
      while (pixels_sent - start < 700) begin
         if (pixels_sent - start >= 200) calm = 1'b0;
         w = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
         h = $urandom_range(0, 8);
         wait_idle();
         set_frame(w, h);
         load_kernel(random_kernel(), random_kernel(), random_kernel());
         repeat ($urandom_range(1, 2)) send_frame();
      end
      calm = 1'b0;
   endtask

   task automatic test_wide_frame();
      wait_idle();
      set_frame(2047, 3);
      load_kernel(random_kernel(), random_kernel(), random_kernel());
      send_frame();
   endtask

   // tall frame, then cut the height mid-frame so the row count wraps
   task automatic test_tall_frame();
      wait_idle();
      set_frame(3, 4095);
      repeat (18) send_pixel(random_pixel());
      wait_idle();
      csr_write(REG_FRAME_HEIGHT, CSR_DATA_BITS'(3));
      send_frame();
   endtask

   task automatic test_backpressure();
      wait_idle();
      set_frame(8, 6);
      load_kernel(random_kernel(), random_kernel(), random_kernel());
      hold_off = 1'b1;
      send_frame();
   endtask

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      filtered_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            error_count++;
            $error("unexpected word: pixel_out %0d frame_end %0b", rsp_pixel_out, rsp_frame_end);
         end else begin
            want = expected_words.pop_front();
            if (rsp_pixel_out !== want.pixel) begin
               error_count++;
               $error("pixel_out: expected %0d, got %0d", want.pixel, rsp_pixel_out);
            end
            if (rsp_frame_end !== want.frame_end) begin
               error_count++;
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
            end
            words_checked++;
            if (want.frame_end) frame_ends++;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pixel_in <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      kernel_top_reg = KERNEL_TOP_RESET;
      kernel_mid_reg = KERNEL_MID_RESET;
      kernel_bottom_reg = KERNEL_BOTTOM_RESET;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 6; i++) window_q[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_corner_cases();
      test_random_frames();
      test_wide_frame();
      test_tall_frame();
      test_backpressure();
      wait_idle();
      $display("Sent %0d pixels, checked %0d filtered words and %0d frame ends, %0d register writes.",
               pixels_sent, words_checked, frame_ends, csr_writes);
      $display("Frames from 3x3 up to 1024 wide and 4095 tall, kernel extremes, resizing mid-frame.");
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
